// ===== rtl/core/kmpd_pkg.sv =====
// Shared types, constants and codes of the key matrix pattern debouncer.
package kmpd_pkg;

    // Matrix geometry.
    localparam int KEY_ROWS  = 8;
    localparam int KEY_COLS  = 16;
    localparam int KEY_SLOTS = 128;

    // Key RAM address width and the width of the unbounded linear index.
    localparam int KEY_AW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int IDXF_W  = 10;

    // Field widths.
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int KIDX_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int PP_W    = 7;
    localparam int CNT_W   = 8;
    localparam int CFG_AW  = 2;

    // Debounced pressed bit of a key byte.
    localparam logic [BYTE_W-1:0] PRESSED_BIT = 8'h80;

    // Register reset values.
    localparam logic [PP_W-1:0]   PRESS_PAT_RST   = 7'd15;
    localparam logic [BYTE_W-1:0] RELEASE_PAT_RST = 8'd128;
    localparam logic [CNT_W-1:0]  FIRST_SCAN_RST  = 8'd8;

    // Input action codes.
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_EVAL   = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;
    localparam logic [1:0] ACT_WAKE   = 2'd3;

    // Scan decision codes.
    localparam logic [1:0] DEC_NONE      = 2'd0;
    localparam logic [1:0] DEC_PERIODIC  = 2'd1;
    localparam logic [1:0] DEC_IMMEDIATE = 2'd2;
    localparam logic [1:0] DEC_SLEEP     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_PRESS_PAT   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RELEASE_PAT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FIRST_SCAN  = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]       action;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             raw_level;
        logic             sink_accepts;
    } kmpd_in_t;

    // Result item.
    typedef struct packed {
        logic              event_valid;
        logic [KIDX_W-1:0] key_index;
        logic              event_to_press;
        logic [1:0]        scan_decision;
        logic              awake;
    } kmpd_out_t;

    // Scan control flags.
    typedef struct packed {
        logic             awake;
        logic             any_active;
        logic             aborted;
        logic [CNT_W-1:0] count;
    } kmpd_flags_t;

    // Key RAM write request.
    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } kmpd_wr_t;

endpackage

// ===== rtl/core/kmpd_key_ram.sv =====
// Key byte RAM with registered read and per-entry valid bits.
module kmpd_key_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [kmpd_pkg::KEY_AW-1:0] rd_addr,
    output logic [kmpd_pkg::BYTE_W-1:0] rd_data,
    input  kmpd_pkg::kmpd_wr_t         wr
);
    import kmpd_pkg::*;

    logic [BYTE_W-1:0] mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] vld_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    // Storage array: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits make never-written entries read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/kmpd_update.sv =====
// Read-modify-write datapath: key byte update, pattern match and scan flags.
module kmpd_update (
    input  kmpd_pkg::kmpd_in_t          item,
    input  logic                        key_ok,
    input  logic [kmpd_pkg::KEY_AW-1:0] key_addr,
    input  logic [kmpd_pkg::BYTE_W-1:0] key_byte,
    input  kmpd_pkg::kmpd_flags_t       flags,
    input  logic [kmpd_pkg::PP_W-1:0]   press_pat,
    input  logic [kmpd_pkg::BYTE_W-1:0] release_pat,
    input  logic [kmpd_pkg::CNT_W-1:0]  first_scan_max,
    output kmpd_pkg::kmpd_wr_t          wr,
    output kmpd_pkg::kmpd_flags_t       flags_next,
    output kmpd_pkg::kmpd_out_t         res
);
    import kmpd_pkg::*;

    logic [BYTE_W-1:0] pp_byte;
    logic [BYTE_W-1:0] new_byte;
    logic              match;
    logic              goes_down;

    // Pattern match: the release pattern exactly; the press pattern exactly when it is one, masked otherwise.
    always_comb
    begin
        pp_byte   = {1'b0, press_pat};
        goes_down = ~key_byte[BYTE_W-1];
        if (key_byte == release_pat)
        begin
            match = 1'b1;
        end
        else if (press_pat == PP_W'(1))
        begin
            match = (key_byte == pp_byte);
        end
        else
        begin
            match = ((key_byte & (pp_byte | PRESSED_BIT)) == pp_byte);
        end
        new_byte = {goes_down, key_byte[BYTE_W-2:0]};
    end

    // Per-action update of the key byte, the flags and the result.
    always_comb
    begin
        wr         = '0;
        wr.addr    = key_addr;
        flags_next = flags;
        res        = '0;
        case (item.action)
            ACT_SAMPLE:
            begin
                if (key_ok)
                begin
                    wr.en   = 1'b1;
                    wr.data = {key_byte[BYTE_W-1], key_byte[BYTE_W-3:0], item.raw_level};
                end
            end
            ACT_EVAL:
            begin
                if (key_ok && !flags.aborted)
                begin
                    if (match && item.sink_accepts)
                    begin
                        wr.en              = 1'b1;
                        wr.data            = new_byte;
                        res.event_valid    = 1'b1;
                        res.key_index      = KIDX_W'(key_addr);
                        res.event_to_press = goes_down;
                        if (new_byte != '0)
                        begin
                            flags_next.any_active = 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        // The sink refused: abort the rest of this scan.
                        flags_next.any_active = 1'b1;
                        flags_next.aborted    = 1'b1;
                    end
                    else if (key_byte != '0)
                    begin
                        flags_next.any_active = 1'b1;
                    end
                end
            end
            ACT_END:
            begin
                if (flags.awake)
                begin
                    if (flags.any_active)
                    begin
                        flags_next.count  = '0;
                        res.scan_decision = DEC_PERIODIC;
                    end
                    else if (flags.count != '0)
                    begin
                        flags_next.count  = flags.count - CNT_W'(1);
                        res.scan_decision = DEC_IMMEDIATE;
                    end
                    else
                    begin
                        flags_next.awake  = 1'b0;
                        res.scan_decision = DEC_SLEEP;
                    end
                end
                flags_next.any_active = 1'b0;
                flags_next.aborted    = 1'b0;
            end
            ACT_WAKE:
            begin
                flags_next.awake = 1'b1;
                flags_next.count = first_scan_max;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
        res.awake = flags_next.awake;
    end

endmodule

// ===== rtl/core/key_matrix_pattern_debouncer.sv =====
// Top level of the key matrix pattern debouncer.
// Each key of the matrix owns one byte in a key RAM: bit 7 is the debounced
// pressed bit, bits 6..0 the raw sample history with the newest in bit 0.
// Every action gives exactly one result. Accepting an item issues the key
// RAM read; completing the update stage writes the updated byte back and
// loads the output register, and waits while a stalled result holds it.
// in_stall stays high while an item is in the update stage, so no new item
// is taken before the last is done and reads and write-backs of the same
// key do not overlap. The output register lets an item be taken while a
// finished result still waits.
// The key RAM needs no clearing pass: per-key valid bits cleared by reset
// make unwritten keys read as zero.
module key_matrix_pattern_debouncer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  kmpd_pkg::kmpd_in_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output kmpd_pkg::kmpd_out_t           out_data,
    input  logic                          cfg_we,
    input  logic [kmpd_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [kmpd_pkg::BYTE_W-1:0]   cfg_data
);
    import kmpd_pkg::*;

    logic [PP_W-1:0]   press_pat_reg;
    logic [BYTE_W-1:0] release_pat_reg;
    logic [CNT_W-1:0]  first_scan_reg;

    kmpd_flags_t flags_reg, flags_next;

    logic              s1_valid_reg, s1_valid_next;
    kmpd_in_t          s1_item_reg;
    logic              s1_ok_reg;
    logic [KEY_AW-1:0] s1_addr_reg;

    logic              out_valid_reg, out_valid_next;
    kmpd_out_t         out_data_reg;

    logic [IDXF_W-1:0] in_idx;
    logic              in_ok;
    logic              accept;
    logic              s1_done;
    logic [BYTE_W-1:0] key_byte;
    kmpd_wr_t          wr;
    kmpd_out_t         s1_res;

    // Linear key index and range check of the incoming item.
    assign in_idx = IDXF_W'(in_data.row) * IDXF_W'(KEY_COLS) + IDXF_W'(in_data.col);
    assign in_ok  = (IDXF_W'(in_data.row) < IDXF_W'(KEY_ROWS)) &&
                    (IDXF_W'(in_data.col) < IDXF_W'(KEY_COLS)) &&
                    (in_idx < IDXF_W'(KEY_SLOTS));

    // Handshake: one item in the update stage at a time.
    assign in_stall  = s1_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign s1_done   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Key RAM, read on transfer and written back when the stage completes.
    kmpd_key_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_idx[KEY_AW-1:0]),
        .rd_data (key_byte),
        .wr      (wr)
    );

    kmpd_wr_t wr_raw;

    // Update datapath for the item in the update stage.
    kmpd_update u_update (
        .item           (s1_item_reg),
        .key_ok         (s1_ok_reg),
        .key_addr       (s1_addr_reg),
        .key_byte       (key_byte),
        .flags          (flags_reg),
        .press_pat      (press_pat_reg),
        .release_pat    (release_pat_reg),
        .first_scan_max (first_scan_reg),
        .wr             (wr_raw),
        .flags_next     (flags_next),
        .res            (s1_res)
    );

    always_comb
    begin
        wr    = wr_raw;
        wr.en = wr_raw.en && s1_done;
    end

    // Control registers, flags and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            flags_reg       <= '0;
            press_pat_reg   <= PRESS_PAT_RST;
            release_pat_reg <= RELEASE_PAT_RST;
            first_scan_reg  <= FIRST_SCAN_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_done)
            begin
                flags_reg <= flags_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRESS_PAT:   press_pat_reg   <= cfg_data[PP_W-1:0];
                    CFG_RELEASE_PAT: release_pat_reg <= cfg_data;
                    CFG_FIRST_SCAN:  first_scan_reg  <= cfg_data;
                    default:         press_pat_reg   <= press_pat_reg;
                endcase
            end
        end
    end

    // Payload registers of the update stage and the output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
            s1_ok_reg   <= in_ok;
            s1_addr_reg <= in_idx[KEY_AW-1:0];
        end
        if (s1_done)
        begin
            out_data_reg <= s1_res;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not enter the update stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> !s1_valid_reg || out_valid_reg)
        else $error("update stage did not complete with a free output");

    a_event_only_on_eval: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && s1_res.event_valid |-> s1_item_reg.action == ACT_EVAL)
        else $error("key event from an action other than evaluate");

    a_decision_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && s1_res.scan_decision != DEC_NONE |-> s1_item_reg.action == ACT_END)
        else $error("scan decision outside end of scan");

    a_sleep_clears_awake: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && s1_res.scan_decision == DEC_SLEEP |=> !flags_reg.awake)
        else $error("still awake after a sleep decision");
`endif

endmodule
